// ----- src/lgsc_pkg.sv -----
// Shared types, widths and constants of the launch grid shape chooser.
// Used by the divider, the multiplier and the top level; depends on nothing.
`default_nettype none
package lgsc_pkg;

   localparam int MAX_DIMS   = 4;
   localparam int EXT_FIELDS = 4;
   localparam int EXT_W      = 32;
   localparam int PCS_W      = 19;
   localparam int BUD_W      = 20;
   localparam int VOL_W      = 64;
   localparam int DIV_W      = 52;
   localparam int DVS_W      = 32;
   localparam int ITER_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;
   localparam int PC_W       = 13;
   localparam int OF_W       = 7;
   localparam int MSV_W      = 40;
   localparam int LAST_DIM_MIN = 32;
   localparam int PRIME_COUNT  = 5;

   localparam logic [PCS_W-1:0] PIECES_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_PROC_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERDECOMPOSE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SHARD     = 2'd2;

   typedef struct packed {
      logic [2:0]       dim_count;
      logic [EXT_W-1:0] extent_0;
      logic [EXT_W-1:0] extent_1;
      logic [EXT_W-1:0] extent_2;
      logic [EXT_W-1:0] extent_3;
      logic [3:0]       no_split_mask;
   } req_type;

   typedef struct packed {
      logic             no_parallel;
      logic [PCS_W-1:0] pieces_0;
      logic [PCS_W-1:0] pieces_1;
      logic [PCS_W-1:0] pieces_2;
      logic [PCS_W-1:0] pieces_3;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_VOL_HI, ST_VOL_LO, ST_VOL_ADD, ST_CHECK,
      ST_Q_MUL, ST_Q_DIV, ST_DWAIT, ST_Q_RES, ST_SQ_MUL, ST_SQ_CMP,
      ST_RR_MUL, ST_RR_CMP, ST_N1_DIV, ST_N1_RES, ST_N2_DIV, ST_N2_RES,
      ST_SA_DIV, ST_SA_RES, ST_SB_DIV, ST_SB_RES, ST_SC_DIV, ST_SC_RES,
      ST_SD_DIV, ST_SD_RES, ST_ND_F, ST_ND_FR, ST_ND_R, ST_ND_RS,
      ST_ND_PICK, ST_FIN, ST_NOPAR
   } state_type;

   function automatic logic [3:0] prime_at(input logic [2:0] idx);
      logic [3:0] f;
      case (idx)
         3'd0:    f = 4'd11;
         3'd1:    f = 4'd7;
         3'd2:    f = 4'd5;
         3'd3:    f = 4'd3;
         default: f = 4'd2;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

// ----- src/lgsc_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on lgsc_pkg for the request and response types.
`default_nettype none
module lgsc_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lgsc_pkg::div_req_type req,
   output lgsc_pkg::div_rsp_type   rsp
);
   import lgsc_pkg::*;

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend << (ITER_W'(DIV_W) - req.iters);
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = req.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule
`default_nettype wire

// ----- src/lgsc_mul.sv -----
// Shared 32 by 32 multiplier with a registered product.
// Depends on lgsc_pkg for the operand type.
`default_nettype none
module lgsc_mul (
   input  wire logic                  clock,
   input  wire lgsc_pkg::mul_req_type req,
   output logic [63:0]                prod
);
   import lgsc_pkg::*;

   logic [63:0] prod_ff, prod_in;

   assign prod_in = 64'(req.a) * 64'(req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- src/launch_grid_shape_chooser_core.sv -----
// Top level of the launch grid shape chooser: sequencer, registers, result register.
// Depends on lgsc_pkg, lgsc_div and lgsc_mul.
//
// An item on the req channel carries a shape of up to four extents and a mask
// of dimensions that stay whole; one item on the rsp channel returns the piece
// count of each dimension or the no-parallel flag. The csr port writes the
// processor count, the overdecomposition factor and the minimum shard volume.
// One item is worked on at a time and req_stall is high until it is finished.
// The volume is formed on the shared multiplier in the states ST_VOL_HI,
// ST_VOL_LO and ST_VOL_ADD for each kept dimension. A two-dimensional split
// first finds the root, then runs a division on the shared divider for every
// divisor candidate tried, then 4 divisions. With three or more dimensions,
// each prime tested takes one division and each factor placed takes one
// division per kept dimension, all on the shared divider.
// Reset restores the register defaults, empties the result register and
// leaves the block idle. A result waits in the result register while
// rsp_stall is high; the next item may be accepted meanwhile, but its result
// is loaded only once the register is free.
`default_nettype none
module launch_grid_shape_chooser_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire lgsc_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output lgsc_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_wen,
   input  wire logic [lgsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lgsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lgsc_pkg::*;

   localparam logic [ITER_W-1:0] IT_Q    = ITER_W'(DIV_W);
   localparam logic [ITER_W-1:0] IT_BUD  = ITER_W'(BUD_W);
   localparam logic [ITER_W-1:0] IT_EXT  = ITER_W'(EXT_W);
   localparam logic [ITER_W-1:0] IT_CEIL = ITER_W'(EXT_W + 1);
   localparam logic [ITER_W-1:0] IT_PC   = ITER_W'(PC_W);
   localparam logic [2:0]        DIMS_N  = 3'(MAX_DIMS);

   function automatic logic [BUD_W-1:0] min_ext(input logic [BUD_W-1:0] a,
                                                input logic [EXT_W-1:0] b);
      return (EXT_W'(a) < b) ? a : b[BUD_W-1:0];
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [OF_W-1:0]  of_ff, of_in;
   logic [MSV_W-1:0] msv_ff, msv_in;

   logic [EXT_W-1:0] ps_ff [EXT_FIELDS];
   logic [EXT_W-1:0] ps_in [EXT_FIELDS];
   logic [1:0]       pd_ff [EXT_FIELDS];
   logic [1:0]       pd_in [EXT_FIELDS];
   logic [EXT_W-1:0] rm_ff [EXT_FIELDS];
   logic [EXT_W-1:0] rm_in [EXT_FIELDS];
   logic [BUD_W-1:0] res_ff [EXT_FIELDS];
   logic [BUD_W-1:0] res_in [EXT_FIELDS];
   logic [2:0]       k_ff, k_in, idx_ff, idx_in, pi_ff, pi_in;
   logic [BUD_W-1:0] budget_ff, budget_in;
   logic [VOL_W-1:0] vol_ff, vol_in, hi_ff, hi_in;
   logic [EXT_W-1:0] nx_ff, nx_in, ny_ff, ny_in, sa_ff, sa_in, s1_ff, s1_in;
   logic             swap_ff, swap_in, qex_ff, qex_in;
   logic [BUD_W-1:0] m_ff, m_in, n1_ff, n1_in, n2_ff, n2_in, d1_ff, d1_in;
   logic [BUD_W-1:0] d2_ff, d2_in, prod_ff, prod_in;
   logic [9:0]       r_ff, r_in;
   logic [3:0]       sb_ff, sb_in;
   logic [PC_W-1:0]  rest_ff, rest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   mul_req_type mul_req;
   logic [63:0] mul_prod;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic             accept, out_free, small_vol;
   logic [MSV_W-1:0] msv_eff;
   logic [BUD_W-1:0] budget_calc;
   logic [9:0]       trial;
   logic [3:0]       fsel;
   logic [23:0]      fprod;

   logic [EXT_W-1:0] prn_ps [EXT_FIELDS];
   logic [1:0]       prn_pd [EXT_FIELDS];
   logic [2:0]       prn_k;
   logic             prn_all_one;
   logic [1:0]       target;

   lgsc_mul u_mul (.clock(clock), .req(mul_req), .prod(mul_prod));
   lgsc_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign msv_eff     = (msv_ff == '0) ? MSV_W'(1) : msv_ff;
   assign small_vol   = vol_ff <= VOL_W'(msv_eff);
   assign budget_calc = BUD_W'(pc_ff) * BUD_W'(of_ff);
   assign trial       = r_ff | (10'd1 << sb_ff);
   assign fsel        = prime_at(pi_ff);
   assign fprod       = 24'(prod_ff) * 24'(fsel);

   always_comb begin : prune
      logic [EXT_W-1:0] ext [EXT_FIELDS];
      logic [2:0]       n;
      n = (req_data.dim_count > DIMS_N) ? DIMS_N : req_data.dim_count;
      ext[0] = req_data.extent_0;
      ext[1] = req_data.extent_1;
      ext[2] = req_data.extent_2;
      ext[3] = req_data.extent_3;
      prn_all_one = 1'b1;
      prn_k = '0;
      for (int i = 0; i < EXT_FIELDS; i++) begin
         prn_ps[i] = '0;
         prn_pd[i] = '0;
      end
      for (int i = 0; i < EXT_FIELDS; i++) begin
         if (3'(i) < n) begin
            if (ext[i] != EXT_W'(1)) prn_all_one = 1'b0;
            if (!req_data.no_split_mask[i] && ext[i] != EXT_W'(1)) begin
               prn_ps[prn_k[1:0]] = ext[i];
               prn_pd[prn_k[1:0]] = 2'(i);
               prn_k = prn_k + 3'd1;
            end
         end
      end
   end

   always_comb begin : pick
      logic [1:0] big, nxt;
      logic       last_ok;
      big = '0;
      for (int i = 1; i < EXT_FIELDS; i++) begin
         if (3'(i) < k_ff && rm_ff[i] > rm_ff[big]) big = 2'(i);
      end
      nxt = '0;
      for (int i = 1; i < EXT_FIELDS - 1; i++) begin
         if (3'(i + 1) < k_ff && rm_ff[i] > rm_ff[nxt]) nxt = 2'(i);
      end
      last_ok = ({1'b0, big} != k_ff - 3'd1) ||
                (rm_ff[big] >= EXT_W'(LAST_DIM_MIN) * EXT_W'(fsel));
      if (last_ok) target = big;
      else if (rm_ff[nxt] >= EXT_W'(fsel)) target = nxt;
      else target = big;
   end

   always_comb begin : next_state
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE:
            if (accept) begin
               state_in = (budget_calc <= BUD_W'(1) || prn_all_one) ? ST_NOPAR : ST_VOL_HI;
            end
         ST_VOL_HI:  state_in = (idx_ff == k_ff) ? ST_CHECK : ST_VOL_LO;
         ST_VOL_LO:  state_in = ST_VOL_ADD;
         ST_VOL_ADD: state_in = ST_VOL_HI;
         ST_CHECK:
            if (small_vol || k_ff == 3'd0) state_in = ST_NOPAR;
            else if (k_ff == 3'd1) state_in = ST_FIN;
            else if (k_ff == 3'd2) begin
               state_in = (vol_ff < VOL_W'(budget_ff)) ? ST_FIN : ST_Q_MUL;
            end else state_in = ST_ND_F;
         ST_Q_MUL: state_in = ST_Q_DIV;
         ST_Q_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_Q_RES;
         end
         ST_DWAIT:  if (div_rsp.done) state_in = ret_ff;
         ST_Q_RES:  state_in = ST_SQ_MUL;
         ST_SQ_MUL: state_in = ST_SQ_CMP;
         ST_SQ_CMP: state_in = (sb_ff == 4'd0) ? ST_RR_MUL : ST_SQ_MUL;
         ST_RR_MUL: state_in = ST_RR_CMP;
         ST_RR_CMP: state_in = ST_N1_DIV;
         ST_N1_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_N1_RES;
         end
         ST_N1_RES: state_in = (div_rsp.remainder != '0) ? ST_N1_DIV : ST_N2_DIV;
         ST_N2_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_N2_RES;
         end
         ST_N2_RES:
            state_in = (div_rsp.remainder != '0 && n2_ff < budget_ff) ? ST_N2_DIV : ST_SA_DIV;
         ST_SA_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_SA_RES;
         end
         ST_SA_RES: state_in = ST_SB_DIV;
         ST_SB_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_SB_RES;
         end
         ST_SB_RES: state_in = ST_SC_DIV;
         ST_SC_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_SC_RES;
         end
         ST_SC_RES: state_in = ST_SD_DIV;
         ST_SD_DIV: begin
            state_in = ST_DWAIT;
            ret_in   = ST_SD_RES;
         end
         ST_SD_RES: state_in = ST_FIN;
         ST_ND_F:
            if (pi_ff == 3'(PRIME_COUNT)) state_in = ST_FIN;
            else if (rest_ff != '0) begin
               state_in = ST_DWAIT;
               ret_in   = ST_ND_FR;
            end
         ST_ND_FR:
            if (div_rsp.remainder != '0) state_in = ST_ND_F;
            else state_in = (fprod > 24'(budget_ff)) ? ST_FIN : ST_ND_R;
         ST_ND_R:
            if (idx_ff == k_ff) state_in = ST_ND_PICK;
            else begin
               state_in = ST_DWAIT;
               ret_in   = ST_ND_RS;
            end
         ST_ND_RS:   state_in = ST_ND_R;
         ST_ND_PICK: state_in = ST_ND_F;
         ST_FIN:     if (out_free) state_in = ST_IDLE;
         ST_NOPAR:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin : unit_ctrl
      logic [EXT_W:0] ceil_num;
      ceil_num  = (EXT_W + 1)'(ps_ff[idx_ff[1:0]]) + (EXT_W + 1)'(res_ff[idx_ff[1:0]])
                  - (EXT_W + 1)'(1);
      req_stall = (state_ff != ST_IDLE);
      mul_req   = '0;
      div_req   = '0;
      case (state_ff)
         ST_VOL_HI: begin
            mul_req.a = vol_ff[63:32];
            mul_req.b = ps_ff[idx_ff[1:0]];
         end
         ST_VOL_LO: begin
            mul_req.a = vol_ff[31:0];
            mul_req.b = ps_ff[idx_ff[1:0]];
         end
         ST_Q_MUL: begin
            mul_req.a = 32'(budget_ff);
            mul_req.b = nx_ff;
         end
         ST_SQ_MUL: begin
            mul_req.a = 32'(trial);
            mul_req.b = 32'(trial);
         end
         ST_RR_MUL: begin
            mul_req.a = 32'(r_ff);
            mul_req.b = 32'(r_ff);
         end
         ST_Q_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_prod[DIV_W-1:0];
            div_req.divisor  = ny_ff;
            div_req.iters    = IT_Q;
         end
         ST_N1_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(budget_ff);
            div_req.divisor  = DVS_W'(n1_ff);
            div_req.iters    = IT_BUD;
         end
         ST_N2_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(budget_ff);
            div_req.divisor  = DVS_W'(n2_ff);
            div_req.iters    = IT_BUD;
         end
         ST_SA_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(nx_ff);
            div_req.divisor  = DVS_W'(n1_ff);
            div_req.iters    = IT_EXT;
         end
         ST_SB_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(ny_ff);
            div_req.divisor  = DVS_W'(d1_ff);
            div_req.iters    = IT_EXT;
         end
         ST_SC_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(nx_ff);
            div_req.divisor  = DVS_W'(n2_ff);
            div_req.iters    = IT_EXT;
         end
         ST_SD_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(ny_ff);
            div_req.divisor  = DVS_W'(d2_ff);
            div_req.iters    = IT_EXT;
         end
         ST_ND_F:
            if (pi_ff != 3'(PRIME_COUNT) && rest_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(rest_ff);
               div_req.divisor  = DVS_W'(fsel);
               div_req.iters    = IT_PC;
            end
         ST_ND_R:
            if (idx_ff != k_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(ceil_num);
               div_req.divisor  = DVS_W'(res_ff[idx_ff[1:0]]);
               div_req.iters    = IT_CEIL;
            end
         default: ;
      endcase
   end

   always_comb begin : data_next
      logic [VOL_W:0]   sum;
      logic [EXT_W-1:0] s2, quo32;
      logic             exact, use1;
      logic [BUD_W-1:0] px, py, r20;
      logic [PCS_W-1:0] pcs [EXT_FIELDS];
      sum   = {1'b0, hi_ff[31:0], 32'd0} + {1'b0, mul_prod};
      quo32 = div_rsp.quotient[EXT_W-1:0];
      s2    = (sa_ff > quo32) ? sa_ff : quo32;
      use1  = s1_ff <= s2;
      px    = use1 ? n1_ff : n2_ff;
      py    = use1 ? d1_ff : d2_ff;
      r20   = BUD_W'(r_ff);
      exact = (mul_prod == 64'(m_ff)) && qex_ff;
      for (int i = 0; i < EXT_FIELDS; i++) pcs[i] = PCS_W'(1);
      for (int i = 0; i < EXT_FIELDS; i++) begin
         if (3'(i) < k_ff) begin
            pcs[pd_ff[i]] = (res_ff[i] > BUD_W'(PIECES_MAX)) ? PIECES_MAX
                                                             : res_ff[i][PCS_W-1:0];
         end
      end

      pc_in = pc_ff;  of_in = of_ff;  msv_in = msv_ff;
      ps_in = ps_ff;  pd_in = pd_ff;  rm_in = rm_ff;  res_in = res_ff;
      k_in = k_ff;  idx_in = idx_ff;  pi_in = pi_ff;  budget_in = budget_ff;
      vol_in = vol_ff;  hi_in = hi_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      sa_in = sa_ff;  s1_in = s1_ff;  swap_in = swap_ff;  qex_in = qex_ff;
      m_in = m_ff;  n1_in = n1_ff;  n2_in = n2_ff;  d1_in = d1_ff;  d2_in = d2_ff;
      prod_in = prod_ff;  r_in = r_ff;  sb_in = sb_ff;  rest_in = rest_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_wen) begin
         case (csr_index)
            CSR_PROC_COUNT:    pc_in  = csr_wdata[PC_W-1:0];
            CSR_OVERDECOMPOSE: of_in  = csr_wdata[OF_W-1:0];
            CSR_MIN_SHARD:     msv_in = csr_wdata[MSV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE:
            if (accept) begin
               ps_in     = prn_ps;
               pd_in     = prn_pd;
               k_in      = prn_k;
               budget_in = budget_calc;
               vol_in    = VOL_W'(1);
               idx_in    = '0;
            end
         ST_VOL_LO: hi_in = mul_prod;
         ST_VOL_ADD: begin
            vol_in = (hi_ff[63:32] != '0 || sum[VOL_W]) ? '1 : sum[VOL_W-1:0];
            idx_in = idx_ff + 3'd1;
         end
         ST_CHECK:
            if (k_ff == 3'd1) begin
               res_in[0] = min_ext(budget_ff, ps_ff[0]);
            end else if (k_ff == 3'd2) begin
               res_in[0] = ps_ff[0][BUD_W-1:0];
               res_in[1] = ps_ff[1][BUD_W-1:0];
               swap_in   = ps_ff[0] > ps_ff[1];
               nx_in     = (ps_ff[0] > ps_ff[1]) ? ps_ff[1] : ps_ff[0];
               ny_in     = (ps_ff[0] > ps_ff[1]) ? ps_ff[0] : ps_ff[1];
               if (ps_ff[0] == '0 && ps_ff[1] == '0) ny_in = EXT_W'(1);
            end else begin
               rest_in = pc_ff;
               prod_in = BUD_W'(1);
               pi_in   = '0;
               for (int i = 0; i < EXT_FIELDS; i++) res_in[i] = BUD_W'(1);
            end
         ST_Q_RES: begin
            m_in   = div_rsp.quotient[BUD_W-1:0];
            qex_in = (div_rsp.remainder == '0);
            r_in   = '0;
            sb_in  = 4'd9;
         end
         ST_SQ_CMP: begin
            if (mul_prod <= 64'(m_ff)) r_in = trial;
            if (sb_ff != 4'd0) sb_in = sb_ff - 4'd1;
         end
         ST_RR_CMP: begin
            n1_in = (r20 == '0) ? BUD_W'(1) : r20;
            if (exact && r20 != '0) n2_in = r20 - BUD_W'(1);
            else n2_in = r20;
            if ((exact && r20 == BUD_W'(1)) || r20 == '0) n2_in = BUD_W'(1);
         end
         ST_N1_RES:
            if (div_rsp.remainder != '0) n1_in = n1_ff - BUD_W'(1);
            else d1_in = div_rsp.quotient[BUD_W-1:0];
         ST_N2_RES:
            if (div_rsp.remainder != '0 && n2_ff < budget_ff) n2_in = n2_ff + BUD_W'(1);
            else d2_in = div_rsp.quotient[BUD_W-1:0];
         ST_SA_RES: sa_in = quo32;
         ST_SB_RES: s1_in = (sa_ff > quo32) ? sa_ff : quo32;
         ST_SC_RES: sa_in = quo32;
         ST_SD_RES:
            if (swap_ff) begin
               res_in[0] = min_ext(py, ny_ff);
               res_in[1] = min_ext(px, nx_ff);
            end else begin
               res_in[0] = min_ext(px, nx_ff);
               res_in[1] = min_ext(py, ny_ff);
            end
         ST_ND_F:
            if (pi_ff != 3'(PRIME_COUNT) && rest_ff == '0) pi_in = pi_ff + 3'd1;
         ST_ND_FR:
            if (div_rsp.remainder != '0) pi_in = pi_ff + 3'd1;
            else begin
               rest_in = div_rsp.quotient[PC_W-1:0];
               if (fprod <= 24'(budget_ff)) begin
                  prod_in = fprod[BUD_W-1:0];
                  idx_in  = '0;
               end
            end
         ST_ND_RS: begin
            rm_in[idx_ff[1:0]] = quo32;
            idx_in = idx_ff + 3'd1;
         end
         ST_ND_PICK: res_in[target] = BUD_W'(24'(res_ff[target]) * 24'(fsel));
         ST_FIN:
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.no_parallel = 1'b0;
               rsp_data_in.pieces_0 = pcs[0];
               rsp_data_in.pieces_1 = pcs[1];
               rsp_data_in.pieces_2 = pcs[2];
               rsp_data_in.pieces_3 = pcs[3];
            end
         ST_NOPAR:
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.no_parallel = 1'b1;
               rsp_data_in.pieces_0 = PCS_W'(1);
               rsp_data_in.pieces_1 = PCS_W'(1);
               rsp_data_in.pieces_2 = PCS_W'(1);
               rsp_data_in.pieces_3 = PCS_W'(1);
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      ps_ff <= ps_in;  pd_ff <= pd_in;  rm_ff <= rm_in;  res_ff <= res_in;
      k_ff <= k_in;  idx_ff <= idx_in;  pi_ff <= pi_in;  budget_ff <= budget_in;
      vol_ff <= vol_in;  hi_ff <= hi_in;  nx_ff <= nx_in;  ny_ff <= ny_in;
      sa_ff <= sa_in;  s1_ff <= s1_in;  swap_ff <= swap_in;  qex_ff <= qex_in;
      m_ff <= m_in;  n1_ff <= n1_in;  n2_ff <= n2_in;  d1_ff <= d1_in;  d2_ff <= d2_in;
      prod_ff <= prod_in;  r_ff <= r_in;  sb_ff <= sb_in;  rest_ff <= rest_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pc_ff        <= PC_W'(1);
         of_ff        <= OF_W'(1);
         msv_ff       <= MSV_W'(8192);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pc_ff        <= pc_in;
         of_ff        <= of_in;
         msv_ff       <= msv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
